### rtl/core/sbox_ddt_histogram_core_macros.svh
// ------------------------------------------------------------------------
// sbox ddt histogram assertion macros
// shared property wrappers, clocked on clk and held off while arst_n is low
// ------------------------------------------------------------------------
`ifndef SBOX_DDT_HISTOGRAM_CORE_MACROS_SVH
`define SBOX_DDT_HISTOGRAM_CORE_MACROS_SVH

// same-cycle implication
`define SDDT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sddt check failed");

// next-cycle implication
`define SDDT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sddt check failed");

`endif

### rtl/core/sddt_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sddt_pkg
// constants, sequencer states and control bundle of the ddt histogram core
// ------------------------------------------------------------------------
package sddt_pkg;

	localparam int IN_BITS    = 5;
	localparam int SBOX_SIZE  = 1 << IN_BITS;
	localparam int SB_W       = IN_BITS;
	// cell counts run 0..SBOX_SIZE, also the histogram address
	localparam int CNT_W      = IN_BITS + 1;
	localparam int FREQ_W     = 2 * IN_BITS + 1;
	localparam int FREQ_DEPTH = SBOX_SIZE + 1;

	// port field widths
	localparam int ENTRY_W = 5;
	localparam int COUNT_W = 6;
	localparam int OCC_W   = 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD,
		ST_EMIT,
		ST_TAIL,
		ST_FINAL
	} seq_state_t;

	typedef struct packed {
		logic             sb_we;
		logic [SB_W-1:0]  sb_waddr;
		logic             issue;
		logic [SB_W-1:0]  issue_i;
		logic [SB_W-1:0]  issue_a;
		logic             issue_bank;
		logic             sweep;
		logic [SB_W-1:0]  sweep_d;
		logic             sweep_bank;
		logic             freq_clear;
		logic             emit_rd;
		logic [CNT_W-1:0] emit_addr;
		logic             emit_final;
	} seq_ctrl_t;

endpackage

### rtl/core/sddt_sbox_mem.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sddt_sbox_mem
// s-box table, one write port and two registered read ports
// ------------------------------------------------------------------------
module sddt_sbox_mem import sddt_pkg::*; (
	input  logic            clk,
	input  logic            we,
	input  logic [SB_W-1:0] waddr,
	input  logic [SB_W-1:0] wdata,
	input  logic [SB_W-1:0] raddr0,
	input  logic [SB_W-1:0] raddr1,
	output logic [SB_W-1:0] rdata0,
	output logic [SB_W-1:0] rdata1
);

	logic [SB_W-1:0] mem [SBOX_SIZE];
	logic [SB_W-1:0] rdata0_q;
	logic [SB_W-1:0] rdata1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0_q <= mem[raddr0];
		rdata1_q <= mem[raddr1];
	end

	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

### rtl/core/sddt_col_bank.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sddt_col_bank
// two banks of column cell counters, one filled while the other is swept
// ------------------------------------------------------------------------
module sddt_col_bank import sddt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             inc_en,
	input  logic             inc_bank,
	input  logic [SB_W-1:0]  inc_d,
	input  logic             sweep_en,
	input  logic             sweep_bank,
	input  logic [SB_W-1:0]  sweep_d,
	output logic [CNT_W-1:0] sweep_count
);

	logic [CNT_W-1:0] cnt0_q [SBOX_SIZE];
	logic [CNT_W-1:0] cnt1_q [SBOX_SIZE];
	logic             inc_hit;

	// an increment landing on the swept cell in the same cycle is folded in
	assign inc_hit     = inc_en && (inc_bank == sweep_bank) && (inc_d == sweep_d);
	assign sweep_count = (sweep_bank ? cnt1_q[sweep_d] : cnt0_q[sweep_d]) + CNT_W'(inc_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < SBOX_SIZE; e++) begin
				cnt0_q[e] <= '0;
				cnt1_q[e] <= '0;
			end
		end else begin
			for (int e = 0; e < SBOX_SIZE; e++) begin
				if (sweep_en && !sweep_bank && (sweep_d == SB_W'(e))) begin
					cnt0_q[e] <= '0;
				end else if (inc_en && !inc_bank && (inc_d == SB_W'(e))) begin
					cnt0_q[e] <= cnt0_q[e] + CNT_W'(1);
				end
				if (sweep_en && sweep_bank && (sweep_d == SB_W'(e))) begin
					cnt1_q[e] <= '0;
				end else if (inc_en && inc_bank && (inc_d == SB_W'(e))) begin
					cnt1_q[e] <= cnt1_q[e] + CNT_W'(1);
				end
			end
		end
	end

endmodule

### rtl/core/sddt_freq_unit.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sddt_freq_unit
// count-value histogram: read-modify-write memory with one shared incrementer
// ------------------------------------------------------------------------
module sddt_freq_unit import sddt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              req_valid,
	input  logic              req_inc,
	input  logic [CNT_W-1:0]  req_addr,
	output logic [FREQ_W-1:0] rsp_value
);

	logic [FREQ_W-1:0]     mem [FREQ_DEPTH];
	logic [FREQ_DEPTH-1:0] vld_q;
	logic [FREQ_W-1:0]     rdata_s1;
	logic                  rvld_s1;
	logic [CNT_W-1:0]      addr_s1;
	logic                  v_s1;
	logic                  inc_s1;
	logic                  fwd_s1;
	logic [FREQ_W-1:0]     fwd_val_s1;
	logic [FREQ_W-1:0]     base;
	logic [FREQ_W-1:0]     sum;
	logic                  wr_en;

	// entries not written since the clear read as zero
	assign base      = fwd_s1 ? fwd_val_s1 : (rvld_s1 ? rdata_s1 : '0);
	assign sum       = base + FREQ_W'(1);
	assign wr_en     = v_s1 && inc_s1;
	assign rsp_value = base;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= sum;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			rdata_s1 <= mem[req_addr];
			rvld_s1  <= vld_q[req_addr];
			addr_s1  <= req_addr;
			inc_s1   <= req_inc;
		end
		fwd_val_s1 <= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[addr_s1] <= 1'b1;
			end
			v_s1 <= req_valid;
			// write landing on the same edge as the read of that address
			fwd_s1 <= req_valid && wr_en && (addr_s1 == req_addr);
		end
	end

endmodule

### rtl/core/sddt_seq.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sddt_seq
// load index, column and cell counters, phase control of the core
// ------------------------------------------------------------------------
module sddt_seq import sddt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output seq_ctrl_t ctrl
);

	localparam logic [SB_W-1:0]  SbMax  = SB_W'(SBOX_SIZE - 1);
	localparam logic [CNT_W-1:0] PhLast = CNT_W'(SBOX_SIZE);

	seq_state_t       state_q;
	seq_state_t       state_nxt;
	logic [SB_W-1:0]  load_q;
	logic [SB_W-1:0]  k_q;
	logic [CNT_W-1:0] p_q;
	logic             accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (load_q == SbMax)) begin
					state_nxt = ST_BUILD;
				end
			end
			ST_BUILD: begin
				if ((p_q == PhLast) && (k_q == SbMax)) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (p_q == PhLast) begin
					state_nxt = ST_TAIL;
				end
			end
			ST_TAIL:  state_nxt = ST_FINAL;
			ST_FINAL: state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy          = 1'b0;
				ctrl.sb_we    = start;
				ctrl.sb_waddr = load_q;
				ctrl.freq_clear = start && (load_q == SbMax);
			end
			ST_BUILD: begin
				// phase p fills column p and sweeps column p-1
				ctrl.issue      = (p_q != PhLast);
				ctrl.issue_i    = k_q;
				ctrl.issue_a    = p_q[SB_W-1:0];
				ctrl.issue_bank = p_q[0];
				ctrl.sweep      = (p_q != '0);
				ctrl.sweep_d    = k_q;
				ctrl.sweep_bank = ~p_q[0];
			end
			ST_EMIT: begin
				ctrl.emit_rd   = 1'b1;
				ctrl.emit_addr = p_q;
			end
			ST_TAIL: begin
			end
			ST_FINAL: begin
				ctrl.emit_final = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			load_q  <= '0;
			k_q     <= '0;
			p_q     <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						load_q <= load_q + SB_W'(1);
					end
					k_q <= '0;
					p_q <= '0;
				end
				ST_BUILD: begin
					k_q <= k_q + SB_W'(1);
					if (k_q == SbMax) begin
						p_q <= (p_q == PhLast) ? '0 : p_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					p_q <= p_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/sbox_ddt_histogram_core.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sbox_ddt_histogram_core
// difference distribution table histogram of a loaded s-box
// ------------------------------------------------------------------------
// a non-final s-box item is taken while idle and busy stays low
// the final item raises busy through 33 build phases, one per column and a
// last sweep, then 33 histogram reads and the tail and final states
// build and emit share the one read-modify-write port of the histogram memory
// results are strobes of one cycle each; the receiver cannot stall them
// reset is asynchronous, active low; counters, banks and valid bits clear at once
// ------------------------------------------------------------------------
module sbox_ddt_histogram_core import sddt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [ENTRY_W-1:0] entry_value,
	output logic               result_valid,
	output logic [COUNT_W-1:0] count_value,
	output logic [OCC_W-1:0]   occurrences,
	output logic               last_result
);

	seq_ctrl_t         ctrl;
	logic [SB_W-1:0]   sb_rd0;
	logic [SB_W-1:0]   sb_rd1;
	logic [SB_W-1:0]   inc_d;
	logic              inc_v_s1;
	logic              inc_bank_s1;
	logic [CNT_W-1:0]  sweep_count;
	logic              freq_req;
	logic [CNT_W-1:0]  freq_addr;
	logic [FREQ_W-1:0] freq_value;
	logic              emit_v_s1;
	logic [CNT_W-1:0]  emit_c_s1;
	logic              emit_hit;
	logic              pend_v_q;
	logic [CNT_W-1:0]  pend_c_q;
	logic [FREQ_W-1:0] pend_n_q;
	logic              res_v_q;
	logic [CNT_W-1:0]  res_c_q;
	logic [FREQ_W-1:0] res_n_q;
	logic              res_last_q;

	// sequencer: load index, phase and cell counters
	sddt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	// s-box table: reads sbox[i] and sbox[i ^ a] together
	sddt_sbox_mem u_sbox (
		.clk    (clk),
		.we     (ctrl.sb_we),
		.waddr  (ctrl.sb_waddr),
		.wdata  (SB_W'(entry_value)),
		.raddr0 (ctrl.issue_i),
		.raddr1 (ctrl.issue_i ^ ctrl.issue_a),
		.rdata0 (sb_rd0),
		.rdata1 (sb_rd1)
	);

	// output difference of the pair from the registered s-box reads
	assign inc_d = sb_rd0 ^ sb_rd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_v_s1 <= 1'b0;
		end else begin
			inc_v_s1 <= ctrl.issue;
		end
	end

	always_ff @(posedge clk) begin
		inc_bank_s1 <= ctrl.issue_bank;
	end

	// column counters, ping-pong between the column being built and the one swept
	sddt_col_bank u_cols (
		.clk         (clk),
		.arst_n      (arst_n),
		.inc_en      (inc_v_s1),
		.inc_bank    (inc_bank_s1),
		.inc_d       (inc_d),
		.sweep_en    (ctrl.sweep),
		.sweep_bank  (ctrl.sweep_bank),
		.sweep_d     (ctrl.sweep_d),
		.sweep_count (sweep_count)
	);

	// histogram: swept cell counts bump their bin, emit reads the bins in order
	assign freq_req  = ctrl.sweep || ctrl.emit_rd;
	assign freq_addr = ctrl.sweep ? sweep_count : ctrl.emit_addr;

	sddt_freq_unit u_freq (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (ctrl.freq_clear),
		.req_valid (freq_req),
		.req_inc   (ctrl.sweep),
		.req_addr  (freq_addr),
		.rsp_value (freq_value)
	);

	// emit: one nonzero bin is held back so the last one can carry the flag
	assign emit_hit = emit_v_s1 && (freq_value != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_v_s1 <= 1'b0;
			pend_v_q  <= 1'b0;
			res_v_q   <= 1'b0;
		end else begin
			emit_v_s1 <= ctrl.emit_rd;
			res_v_q   <= (emit_hit && pend_v_q) || (ctrl.emit_final && pend_v_q);
			if (emit_hit) begin
				pend_v_q <= 1'b1;
			end else if (ctrl.emit_final) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		emit_c_s1 <= ctrl.emit_addr;
		if (emit_hit) begin
			pend_c_q <= emit_c_s1;
			pend_n_q <= freq_value;
		end
		if (emit_hit || ctrl.emit_final) begin
			res_c_q    <= pend_c_q;
			res_n_q    <= pend_n_q;
			res_last_q <= ctrl.emit_final;
		end
	end

	assign result_valid = res_v_q;
	assign count_value  = COUNT_W'(res_c_q);
	assign occurrences  = OCC_W'(res_n_q);
	assign last_result  = res_last_q;

endmodule

### rtl/core/sddt_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sddt_checker
// port-level checks of the ddt histogram core, bound to the top level
// ------------------------------------------------------------------------
`include "sbox_ddt_histogram_core_macros.svh"

module sddt_checker import sddt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               result_valid,
	input logic [COUNT_W-1:0] count_value,
	input logic [OCC_W-1:0]   occurrences,
	input logic               last_result
);

	localparam logic [COUNT_W-1:0] CntMax = COUNT_W'(SBOX_SIZE);

	// every reported bin is nonzero and within the count range
	`SDDT_ASSERT_NOW(a_occ_nonzero, result_valid, occurrences != '0)
	`SDDT_ASSERT_NOW(a_count_range, result_valid, count_value <= CntMax)
	// nothing follows the flagged item of a table
	`SDDT_ASSERT_NEXT(a_last_ends, result_valid && last_result, !result_valid)
	// busy only starts from an accepted item
	`SDDT_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start))
	// the table ends with its flagged item as busy drops
	`SDDT_ASSERT_NOW(a_end_flag, $fell(busy), result_valid && last_result)

endmodule

bind sbox_ddt_histogram_core sddt_checker u_sddt_checker (.*);
